[src/mpq_pkg.sv]
// Shared types and constants for the sorted max priority queue.
package mpq_pkg;

    // Storage and field sizes.
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int OCC_BITS   = 5;

    // Item kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Input word.
    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } mpq_in_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0]  removed_value;
        logic                was_empty;
        logic                dropped_full;
        logic [OCC_BITS-1:0] occupancy;
    } mpq_out_t;

    // Operations the controller orders from the datapath.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_DROP,
        OP_EMPTY
    } mpq_op_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } mpq_state_t;

    // Command from controller to datapath.
    typedef struct packed {
        mpq_op_t op;
    } mpq_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic empty;
        logic full;
    } mpq_status_t;

endpackage

[src/mpq_datapath.sv]
// Datapath of the priority queue: sorted cell row, entry count and result register.
module mpq_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mpq_pkg::mpq_cmd_t    cmd,
    input  mpq_pkg::mpq_in_t     item,
    output mpq_pkg::mpq_status_t status,
    output mpq_pkg::mpq_out_t    result
);
    import mpq_pkg::*;

    logic signed [VALUE_BITS-1:0] cells_reg  [CAPACITY];
    logic signed [VALUE_BITS-1:0] cells_next [CAPACITY];
    logic [COUNT_BITS-1:0]        count_reg;
    logic [COUNT_BITS-1:0]        count_next;
    mpq_out_t                     result_reg;
    mpq_out_t                     result_next;
    logic signed [VALUE_BITS-1:0] new_value;
    logic [CAPACITY-1:0]          keep;

    assign new_value = VALUE_BITS'(item.value);

    // Flags for the controller.
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == COUNT_BITS'(CAPACITY));

    // Each held entry not smaller than the new value stays in place;
    // since the row is sorted these cells form a prefix.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep[i] = (COUNT_BITS'(i) < count_reg) && !(cells_reg[i] < new_value);
        end
    end

    // Next contents of every cell, chosen in parallel.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (cmd.op == OP_INSERT)
            begin
                if (keep[i])
                begin
                    cells_next[i] = cells_reg[i];
                end
                else if (i == 0)
                begin
                    cells_next[i] = new_value;
                end
                else if (keep[i-1])
                begin
                    cells_next[i] = new_value;
                end
                else
                begin
                    cells_next[i] = cells_reg[i-1];
                end
            end
            else if (cmd.op == OP_REMOVE)
            begin
                if (i < CAPACITY - 1)
                begin
                    cells_next[i] = cells_reg[i+1];
                end
            end
        end
    end

    // Entry count and result word.
    always_comb
    begin
        count_next  = count_reg;
        result_next = result_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
            OP_REMOVE:
            begin
                count_next = count_reg - COUNT_BITS'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (cmd.op != OP_NONE)
        begin
            result_next.removed_value = '0;
            result_next.was_empty     = 1'b0;
            result_next.dropped_full  = 1'b0;
            if (cmd.op == OP_REMOVE)
            begin
                result_next.removed_value = 32'(cells_reg[0]);
            end
            if (cmd.op == OP_EMPTY)
            begin
                result_next.removed_value = '1;
                result_next.was_empty     = 1'b1;
            end
            if (cmd.op == OP_DROP)
            begin
                result_next.dropped_full = 1'b1;
            end
            result_next.occupancy = OCC_BITS'(count_next);
        end
    end

    // Cell row and result word need no reset.
    always_ff @(posedge clk)
    begin
        cells_reg  <= cells_next;
        result_reg <= result_next;
    end

    // Entry count starts empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign result = result_reg;

endmodule

[src/mpq_ctrl.sv]
// Controller of the priority queue: accepts a word, picks the operation, strobes the result.
module mpq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    input  mpq_pkg::mpq_status_t status,
    output mpq_pkg::mpq_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import mpq_pkg::*;

    mpq_state_t state_reg;
    mpq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        busy       = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RESP;
                    if (kind == KIND_INSERT)
                    begin
                        cmd.op = status.full ? OP_DROP : OP_INSERT;
                    end
                    else
                    begin
                        cmd.op = status.empty ? OP_EMPTY : OP_REMOVE;
                    end
                end
            end
            ST_RESP:
            begin
                busy       = 1'b1;
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/max_priority_queue.sv]
// Top level of the sorted max priority queue.
//
// A word is accepted at a rising edge where start is high and busy is low.
// item.kind selects an insert of item.value or a removal of the largest
// entry. Entries are held in a row of registers kept in descending order;
// every cell decides its next content in parallel.
// The result word appears on result in the cycle after acceptance, marked
// by done for exactly one cycle; busy is high in that same cycle.
// The two-state controller takes no new word while busy, so a new word is
// accepted only once the result of the last one has been given.
// A removal from an empty queue answers -1 with was_empty set; an insert
// into a full queue is dropped with dropped_full set. Every result reports
// the occupancy after the item.
// Reset empties the queue at once; held values are not cleared.
// The receiver cannot stall: a result is taken at the edge that ends its cycle.
module max_priority_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mpq_pkg::mpq_in_t  item,
    output logic              done,
    output mpq_pkg::mpq_out_t result
);
    import mpq_pkg::*;

    mpq_cmd_t    cmd;
    mpq_status_t status;

    // Sequencing.
    mpq_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Storage and result.
    mpq_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .status (status),
        .result (result)
    );

endmodule
